[rtl/sadtm_pkg.sv]
// shared types, constants and codes of the template matcher
package sadtm_pkg;

   localparam int MAX_OFFSETS_DEF  = 16;
   localparam int MAX_TEMPLATE_DEF = 32;
   localparam int WINDOW_SIDE_DEF  = 64;

   localparam int EDGE_MARGIN = 15;
   localparam int SAT_RESET   = 30000000;

   localparam int OP_W       = 2;
   localparam int COORD_W    = 6;
   localparam int GRAY_W     = 8;
   localparam int WIN_W      = GRAY_W + 1;
   localparam int SUM_W      = 26;
   localparam int POS_W      = 13;
   localparam int CENTER_W   = 12;
   localparam int OFFS_CFG_W = 5;
   localparam int TPL_CFG_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_TPL = 2'd0,
      OP_LOAD_WIN = 2'd1,
      OP_SEARCH   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SAT_LIMIT    = 3'd0,
      REG_CENTER_X     = 3'd1,
      REG_CENTER_Y     = 3'd2,
      REG_OFFSETS_WIDE = 3'd3,
      REG_OFFSETS_HIGH = 3'd4,
      REG_TPL_WIDE     = 3'd5,
      REG_TPL_HIGH     = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } scan_state_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [COORD_W-1:0] pix_row;
      logic [COORD_W-1:0] pix_col;
      logic [GRAY_W-1:0]  gray;
      logic               in_image;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   match_x;
      logic [POS_W-1:0]   match_y;
      logic [SUM_W-1:0]   best_sum;
   } rsp_type;

   // control that travels with each pixel read
   typedef struct packed {
      logic valid;
      logic active;
      logic first_pix;
      logic last_pix;
      logic origin;
      logic final_pix;
   } pix_tag_type;

endpackage

[rtl/sadtm_store.sv]
// window and template pixel memories, one write and one registered read port each
module sadtm_store #(
   parameter int WINDOW_SIDE  = sadtm_pkg::WINDOW_SIDE_DEF,
   parameter int MAX_TEMPLATE = sadtm_pkg::MAX_TEMPLATE_DEF
) (
   input  logic clock,
   input  logic win_we,
   input  logic [$clog2(WINDOW_SIDE*WINDOW_SIDE)-1:0] win_waddr,
   input  logic [sadtm_pkg::WIN_W-1:0] win_wdata,
   input  logic [$clog2(WINDOW_SIDE*WINDOW_SIDE)-1:0] win_raddr,
   output logic [sadtm_pkg::WIN_W-1:0] win_rdata,
   input  logic tpl_we,
   input  logic [((MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE*MAX_TEMPLATE) : 1)-1:0] tpl_waddr,
   input  logic [sadtm_pkg::GRAY_W-1:0] tpl_wdata,
   input  logic [((MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE*MAX_TEMPLATE) : 1)-1:0] tpl_raddr,
   output logic [sadtm_pkg::GRAY_W-1:0] tpl_rdata
);
   import sadtm_pkg::*;

   localparam int WIN_DEPTH = WINDOW_SIDE * WINDOW_SIDE;
   localparam int TPL_DEPTH = MAX_TEMPLATE * MAX_TEMPLATE;

   logic [WIN_W-1:0]  win_mem [WIN_DEPTH];
   logic [GRAY_W-1:0] tpl_mem [TPL_DEPTH];
   logic [WIN_W-1:0]  win_rdata_ff;
   logic [GRAY_W-1:0] tpl_rdata_ff;

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= win_wdata;
      end
      win_rdata_ff <= win_mem[win_raddr];
   end

   always_ff @(posedge clock) begin
      if (tpl_we) begin
         tpl_mem[tpl_waddr] <= tpl_wdata;
      end
      tpl_rdata_ff <= tpl_mem[tpl_raddr];
   end

   assign win_rdata = win_rdata_ff;
   assign tpl_rdata = tpl_rdata_ff;

endmodule

[rtl/sadtm_scan.sv]
// offset and pixel sequencer: walks offsets and template pixels, issues store reads
module sadtm_scan #(
   parameter int MAX_OFFSETS  = sadtm_pkg::MAX_OFFSETS_DEF,
   parameter int MAX_TEMPLATE = sadtm_pkg::MAX_TEMPLATE_DEF,
   parameter int WINDOW_SIDE  = sadtm_pkg::WINDOW_SIDE_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic search_go,
   input  logic [((MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1)-1:0] ow_last,
   input  logic [((MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1)-1:0] oh_last,
   input  logic [((MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1)-1:0] tw_last,
   input  logic [((MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1)-1:0] th_last,
   input  logic no_pixels,
   input  logic rsp_done,
   output logic busy,
   output logic [$clog2(WINDOW_SIDE*WINDOW_SIDE)-1:0] win_raddr,
   output logic [((MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE*MAX_TEMPLATE) : 1)-1:0] tpl_raddr,
   output sadtm_pkg::pix_tag_type tag,
   output logic [((MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1)-1:0] tag_oi,
   output logic [((MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1)-1:0] tag_oj
);
   import sadtm_pkg::*;

   localparam int OI_W = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
   localparam int TI_W = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
   localparam int RW   = $clog2(MAX_OFFSETS + MAX_TEMPLATE);
   localparam int WA_W = $clog2(WINDOW_SIDE * WINDOW_SIDE);
   localparam int TA_W = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE * MAX_TEMPLATE) : 1;

   scan_state_type state_ff, state_in;
   logic [OI_W-1:0] oi_ff, oi_in, oj_ff, oj_in;
   logic [TI_W-1:0] y_ff, y_in, x_ff, x_in;
   pix_tag_type     tag_ff, tag_in;
   logic [OI_W-1:0] tag_oi_ff, tag_oj_ff;
   logic            running;
   logic            x_end, y_end, j_end, i_end, pix_last, scan_final;
   logic [RW-1:0]   win_row, win_col;
   logic            in_window;

   assign x_end      = (x_ff == tw_last);
   assign y_end      = (y_ff == th_last);
   assign j_end      = (oj_ff == ow_last);
   assign i_end      = (oi_ff == oh_last);
   assign pix_last   = x_end && y_end;
   assign scan_final = pix_last && j_end && i_end;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (search_go) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (scan_final) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy    = 1'b1;
      running = 1'b0;
      unique case (state_ff)
         ST_IDLE:  busy    = 1'b0;
         ST_RUN:   running = 1'b1;
         ST_DRAIN: running = 1'b0;
         default:  busy    = 1'b1;
      endcase
   end

   // nested counters, template column innermost
   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      oj_in = oj_ff;
      oi_in = oi_ff;
      if (search_go) begin
         x_in  = '0;
         y_in  = '0;
         oj_in = '0;
         oi_in = '0;
      end else if (running) begin
         x_in = x_end ? '0 : x_ff + 1'b1;
         if (x_end) y_in = y_end ? '0 : y_ff + 1'b1;
         if (pix_last) oj_in = j_end ? '0 : oj_ff + 1'b1;
         if (pix_last && j_end) oi_in = i_end ? '0 : oi_ff + 1'b1;
      end
   end

   assign win_row   = RW'(oi_ff) + RW'(y_ff);
   assign win_col   = RW'(oj_ff) + RW'(x_ff);
   assign in_window = (int'(win_row) < WINDOW_SIDE) && (int'(win_col) < WINDOW_SIDE);
   assign win_raddr = WA_W'(int'(win_row) * WINDOW_SIDE + int'(win_col));
   assign tpl_raddr = TA_W'(int'(y_ff) * MAX_TEMPLATE + int'(x_ff));

   always_comb begin
      tag_in.valid     = running;
      tag_in.active    = in_window && !no_pixels;
      tag_in.first_pix = (x_ff == '0) && (y_ff == '0);
      tag_in.last_pix  = pix_last;
      tag_in.origin    = (oi_ff == '0) && (oj_ff == '0);
      tag_in.final_pix = scan_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag_ff   <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         oj_ff    <= '0;
         oi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         oj_ff    <= oj_in;
         oi_ff    <= oi_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_oi_ff <= oi_ff;
      tag_oj_ff <= oj_ff;
   end

   assign tag    = tag_ff;
   assign tag_oi = tag_oi_ff;
   assign tag_oj = tag_oj_ff;

   a_tag_from_run: assert property (@(posedge clock) disable iff (reset)
      tag_ff.valid |-> $past(state_ff) == ST_RUN)
      else $error("pixel tag issued outside the scan");

endmodule

[rtl/sadtm_accum.sv]
// difference accumulator, arg-min tracker and result register
module sadtm_accum #(
   parameter int MAX_OFFSETS  = sadtm_pkg::MAX_OFFSETS_DEF,
   parameter int MAX_TEMPLATE = sadtm_pkg::MAX_TEMPLATE_DEF
) (
   input  logic clock,
   input  logic reset,
   input  sadtm_pkg::pix_tag_type tag,
   input  logic [((MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1)-1:0] tag_oi,
   input  logic [((MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1)-1:0] tag_oj,
   input  logic [sadtm_pkg::WIN_W-1:0] win_rdata,
   input  logic [sadtm_pkg::GRAY_W-1:0] tpl_rdata,
   input  logic [sadtm_pkg::SUM_W-1:0] sat_limit,
   input  logic [sadtm_pkg::CENTER_W-1:0] left_edge,
   input  logic [sadtm_pkg::CENTER_W-1:0] top_edge,
   input  logic [$clog2(MAX_TEMPLATE+1)-1:0] tw_eff,
   output logic rsp_strobe,
   output sadtm_pkg::rsp_type rsp_data
);
   import sadtm_pkg::*;

   localparam int OI_W = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;

   logic [GRAY_W-1:0] pix_a, pix_b, diff, addend;
   logic [SUM_W-1:0]  base, clamped;
   logic [SUM_W:0]    grown;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic              cand_valid_ff, cand_valid_in;
   logic [SUM_W-1:0]  cand_sum_ff, cand_sum_in;
   logic [OI_W-1:0]   cand_oi_ff, cand_oi_in, cand_oj_ff, cand_oj_in;
   logic              cand_origin_ff, cand_origin_in, cand_final_ff, cand_final_in;

   logic              take;
   logic [SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [OI_W-1:0]   best_oi_ff, best_oi_in, best_oj_ff, best_oj_in;
   logic              found_ff, found_in;
   logic              done_ff, done_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // stage 1: absolute difference and clamped running sum
   assign pix_a   = win_rdata[GRAY_W-1:0];
   assign pix_b   = tpl_rdata;
   assign diff    = (pix_a > pix_b) ? pix_a - pix_b : pix_b - pix_a;
   assign addend  = (tag.active && win_rdata[GRAY_W]) ? diff : '0;
   assign base    = tag.first_pix ? '0 : sum_ff;
   assign grown   = {1'b0, base} + (SUM_W+1)'(addend);
   assign clamped = (grown > {1'b0, sat_limit}) ? sat_limit : grown[SUM_W-1:0];
   assign sum_in  = tag.valid ? clamped : sum_ff;

   always_comb begin
      cand_valid_in  = tag.valid && tag.last_pix;
      cand_sum_in    = clamped;
      cand_oi_in     = tag_oi;
      cand_oj_in     = tag_oj;
      cand_origin_in = tag.origin;
      cand_final_in  = tag.final_pix;
   end

   // stage 2: first strict minimum, offset (0,0) seeds it
   assign take = cand_valid_ff && (cand_origin_ff || (cand_sum_ff < best_sum_ff));

   always_comb begin
      best_sum_in = best_sum_ff;
      best_oi_in  = best_oi_ff;
      best_oj_in  = best_oj_ff;
      found_in    = found_ff;
      if (take) begin
         best_sum_in = cand_sum_ff;
         best_oi_in  = cand_oi_ff;
         best_oj_in  = cand_oj_ff;
         found_in    = !cand_origin_ff;
      end
      done_in = cand_valid_ff && cand_final_ff;
   end

   // stage 3: match point and result register
   always_comb begin
      rsp_strobe_in        = done_ff;
      rsp_data_in          = rsp_data_ff;
      if (done_ff) begin
         rsp_data_in.found    = found_ff;
         rsp_data_in.match_x  = POS_W'(best_oj_ff) + POS_W'(left_edge) + POS_W'(tw_eff);
         rsp_data_in.match_y  = POS_W'(best_oi_ff) + POS_W'(top_edge);
         rsp_data_in.best_sum = best_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
         done_ff       <= done_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff         <= sum_in;
      cand_sum_ff    <= cand_sum_in;
      cand_oi_ff     <= cand_oi_in;
      cand_oj_ff     <= cand_oj_in;
      cand_origin_ff <= cand_origin_in;
      cand_final_ff  <= cand_final_in;
      best_sum_ff    <= best_sum_in;
      best_oi_ff     <= best_oi_in;
      best_oj_ff     <= best_oj_in;
      found_ff       <= found_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_sum_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> rsp_data_ff.best_sum <= sat_limit)
      else $error("reported sum above saturation ceiling");

   a_not_found_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (rsp_data_ff.found || (best_oi_ff == '0 && best_oj_ff == '0)))
      else $error("found clear but best offset is not the origin");

endmodule

[rtl/sad_template_match_argmin.sv]
// top level of the sum-of-absolute-differences template matcher
//
// usage: load template pixels (operation load template) and window pixels with their
// in-image flag (operation load window) one transaction per cycle while busy is low;
// each load is written in the cycle it is taken and gives no result. a search
// transaction walks every candidate offset in row-major order and, for each, every
// template pixel, through one read port of each pixel memory and a single
// accumulator. busy stays high from the search transaction until its result has
// been shown. the result is shown on rsp_data, marked by rsp_strobe for exactly one
// cycle; the receiver cannot stall, so it must take it then. the user must write
// configuration registers through the csr port only while busy is low; the block
// does not enforce this. the memories are not cleared: pixels a search reads must
// have been loaded first.
module sad_template_match_argmin #(
   parameter int MAX_OFFSETS  = sadtm_pkg::MAX_OFFSETS_DEF,
   parameter int MAX_TEMPLATE = sadtm_pkg::MAX_TEMPLATE_DEF,
   parameter int WINDOW_SIDE  = sadtm_pkg::WINDOW_SIDE_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  sadtm_pkg::req_type req_data,
   output logic rsp_strobe,
   output sadtm_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [sadtm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sadtm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sadtm_pkg::*;

   localparam int OI_W = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
   localparam int TI_W = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
   localparam int TC_W = $clog2(MAX_TEMPLATE + 1);
   localparam int WA_W = $clog2(WINDOW_SIDE * WINDOW_SIDE);
   localparam int TA_W = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE * MAX_TEMPLATE) : 1;

   // counts outside [lo, hi] saturate
   function automatic int clamp_count(input int v, input int lo, input int hi);
      int r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

   // edge of the search area, floored at zero
   function automatic int edge_of(input int c);
      return (c > EDGE_MARGIN) ? c - EDGE_MARGIN : 0;
   endfunction

   // configuration registers
   logic [SUM_W-1:0]      sat_limit_ff, sat_limit_in;
   logic [CENTER_W-1:0]   center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [OFFS_CFG_W-1:0] offsets_wide_ff, offsets_wide_in;
   logic [OFFS_CFG_W-1:0] offsets_high_ff, offsets_high_in;
   logic [TPL_CFG_W-1:0]  tpl_wide_ff, tpl_wide_in, tpl_high_ff, tpl_high_in;

   // derived search geometry
   int                    tw_int, th_int;
   logic [OI_W-1:0]       ow_last, oh_last;
   logic [TI_W-1:0]       tw_last, th_last;
   logic [TC_W-1:0]       tw_eff;
   logic                  no_pixels;
   logic [CENTER_W-1:0]   left_edge, top_edge;

   // transaction decode
   logic                  accept, search_go;
   logic                  win_we, tpl_we;
   logic [WA_W-1:0]       win_waddr, win_raddr;
   logic [TA_W-1:0]       tpl_waddr, tpl_raddr;
   logic [WIN_W-1:0]      win_wdata, win_rdata;
   logic [GRAY_W-1:0]     tpl_rdata;

   pix_tag_type           tag;
   logic [OI_W-1:0]       tag_oi, tag_oj;

   // register writes, unknown indexes ignored
   always_comb begin
      sat_limit_in    = sat_limit_ff;
      center_x_in     = center_x_ff;
      center_y_in     = center_y_ff;
      offsets_wide_in = offsets_wide_ff;
      offsets_high_in = offsets_high_ff;
      tpl_wide_in     = tpl_wide_ff;
      tpl_high_in     = tpl_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SAT_LIMIT:    sat_limit_in    = csr_wdata[SUM_W-1:0];
            REG_CENTER_X:     center_x_in     = csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y:     center_y_in     = csr_wdata[CENTER_W-1:0];
            REG_OFFSETS_WIDE: offsets_wide_in = csr_wdata[OFFS_CFG_W-1:0];
            REG_OFFSETS_HIGH: offsets_high_in = csr_wdata[OFFS_CFG_W-1:0];
            REG_TPL_WIDE:     tpl_wide_in     = csr_wdata[TPL_CFG_W-1:0];
            REG_TPL_HIGH:     tpl_high_in     = csr_wdata[TPL_CFG_W-1:0];
            default:          sat_limit_in    = sat_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_limit_ff    <= SUM_W'(SAT_RESET);
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         offsets_wide_ff <= OFFS_CFG_W'(16);
         offsets_high_ff <= OFFS_CFG_W'(16);
         tpl_wide_ff     <= TPL_CFG_W'(32);
         tpl_high_ff     <= TPL_CFG_W'(32);
      end else begin
         sat_limit_ff    <= sat_limit_in;
         center_x_ff     <= center_x_in;
         center_y_ff     <= center_y_in;
         offsets_wide_ff <= offsets_wide_in;
         offsets_high_ff <= offsets_high_in;
         tpl_wide_ff     <= tpl_wide_in;
         tpl_high_ff     <= tpl_high_in;
      end
   end

   // stable geometry in a search relies on the user writing config only while idle
   always_comb begin
      ow_last   = OI_W'(clamp_count(int'(offsets_wide_ff), 1, MAX_OFFSETS) - 1);
      oh_last   = OI_W'(clamp_count(int'(offsets_high_ff), 1, MAX_OFFSETS) - 1);
      tw_int    = clamp_count(int'(tpl_wide_ff), 0, MAX_TEMPLATE);
      th_int    = clamp_count(int'(tpl_high_ff), 0, MAX_TEMPLATE);
      tw_eff    = TC_W'(tw_int);
      // empty template still walks one masked pixel per offset
      no_pixels = (tw_int == 0) || (th_int == 0);
      tw_last   = TI_W'((tw_int > 0) ? tw_int - 1 : 0);
      th_last   = TI_W'((th_int > 0) ? th_int - 1 : 0);
      left_edge = CENTER_W'(edge_of(int'(center_x_ff)));
      top_edge  = CENTER_W'(edge_of(int'(center_y_ff)));
   end

   // transaction decode: loads write straight into the pixel memories
   assign accept    = start && !busy;
   assign search_go = accept && (req_data.operation == OP_SEARCH);
   assign tpl_we    = accept && (req_data.operation == OP_LOAD_TPL)
                      && (int'(req_data.pix_row) < MAX_TEMPLATE)
                      && (int'(req_data.pix_col) < MAX_TEMPLATE);
   assign win_we    = accept && (req_data.operation == OP_LOAD_WIN)
                      && (int'(req_data.pix_row) < WINDOW_SIDE)
                      && (int'(req_data.pix_col) < WINDOW_SIDE);
   assign tpl_waddr = TA_W'(int'(req_data.pix_row) * MAX_TEMPLATE + int'(req_data.pix_col));
   assign win_waddr = WA_W'(int'(req_data.pix_row) * WINDOW_SIDE + int'(req_data.pix_col));
   assign win_wdata = {req_data.in_image, req_data.gray};

   sadtm_store #(
      .WINDOW_SIDE  (WINDOW_SIDE),
      .MAX_TEMPLATE (MAX_TEMPLATE)
   ) u_store (
      .clock     (clock),
      .win_we    (win_we),
      .win_waddr (win_waddr),
      .win_wdata (win_wdata),
      .win_raddr (win_raddr),
      .win_rdata (win_rdata),
      .tpl_we    (tpl_we),
      .tpl_waddr (tpl_waddr),
      .tpl_wdata (req_data.gray),
      .tpl_raddr (tpl_raddr),
      .tpl_rdata (tpl_rdata)
   );

   sadtm_scan #(
      .MAX_OFFSETS  (MAX_OFFSETS),
      .MAX_TEMPLATE (MAX_TEMPLATE),
      .WINDOW_SIDE  (WINDOW_SIDE)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .search_go (search_go),
      .ow_last   (ow_last),
      .oh_last   (oh_last),
      .tw_last   (tw_last),
      .th_last   (th_last),
      .no_pixels (no_pixels),
      .rsp_done  (rsp_strobe),
      .busy      (busy),
      .win_raddr (win_raddr),
      .tpl_raddr (tpl_raddr),
      .tag       (tag),
      .tag_oi    (tag_oi),
      .tag_oj    (tag_oj)
   );

   sadtm_accum #(
      .MAX_OFFSETS  (MAX_OFFSETS),
      .MAX_TEMPLATE (MAX_TEMPLATE)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .tag        (tag),
      .tag_oi     (tag_oi),
      .tag_oj     (tag_oj),
      .win_rdata  (win_rdata),
      .tpl_rdata  (tpl_rdata),
      .sat_limit  (sat_limit_ff),
      .left_edge  (left_edge),
      .top_edge   (top_edge),
      .tw_eff     (tw_eff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transaction outside a search");

   a_search_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation == OP_SEARCH) |=> busy)
      else $error("search transaction did not raise busy");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the sum-of-absolute-differences template matcher
module tb_top;
   import sadtm_pkg::*;

   // codes the package leaves unnamed: a spare operation and a spare register slot
   localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam int WIN_CELLS = WINDOW_SIDE_DEF * WINDOW_SIDE_DEF;
   localparam int TPL_CELLS = MAX_TEMPLATE_DEF * MAX_TEMPLATE_DEF;
   localparam int REQ_W     = $bits(req_type);

   // slowest correct run: some 90 searches of at most 2500 pixel steps, a handful of up
   // to 20000, the directed searches, and about 1500 transactions at the worst idle rate;
   // the limit leaves plenty of headroom over all of that
   localparam int CYCLE_LIMIT = 4000000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow copy of the pixel memories, with a note of which entries hold data
   logic [WIN_W-1:0]  win_pix [WIN_CELLS];
   logic [GRAY_W-1:0] tpl_pix [TPL_CELLS];
   bit                win_loaded [WIN_CELLS];
   bit                tpl_loaded [TPL_CELLS];

   // shadow copy of the registers, at their reset values
   logic [SUM_W-1:0]      cfg_sat = SUM_W'(SAT_RESET);
   logic [CENTER_W-1:0]   cfg_cx  = '0;
   logic [CENTER_W-1:0]   cfg_cy  = '0;
   logic [OFFS_CFG_W-1:0] cfg_ow  = 5'd16;
   logic [OFFS_CFG_W-1:0] cfg_oh  = 5'd16;
   logic [TPL_CFG_W-1:0]  cfg_tw  = 6'd32;
   logic [TPL_CFG_W-1:0]  cfg_th  = 6'd32;

   // best-match results still owed by the block, oldest first
   rsp_type pending_matches [$];

   int fault_count     = 0;
   int items_sent      = 0;
   int searches_sent   = 0;
   int sender_idle_pct = 0;
   int cycle_count     = 0;

   sad_template_match_argmin dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   // offset counts: zero means one, anything past the maximum saturates
   function automatic int unsigned eff_offsets(input logic [OFFS_CFG_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_OFFSETS_DEF)
         return MAX_OFFSETS_DEF;
      return 32'(v);
   endfunction

   // template size: zero is allowed, anything past the maximum saturates
   function automatic int unsigned eff_tpl(input logic [TPL_CFG_W-1:0] v);
      return (v > MAX_TEMPLATE_DEF) ? MAX_TEMPLATE_DEF : 32'(v);
   endfunction

   // left or top edge of the search area, floored at zero
   function automatic int unsigned edge_start(input logic [CENTER_W-1:0] v);
      return (v > EDGE_MARGIN) ? 32'(v) - EDGE_MARGIN : 0;
   endfunction

   // clamped difference sum of the template placed at one offset
   function automatic int unsigned offset_cost(input int unsigned oi, input int unsigned oj,
                                               input int unsigned th, input int unsigned tw);
      int unsigned acc;
      int unsigned r;
      int unsigned c;
      int unsigned a;
      int unsigned b;
      logic [WIN_W-1:0] px;
      acc = 0;
      for (int y = 0; y < th; y++) begin
         for (int x = 0; x < tw; x++) begin
            r = oi + y;
            c = oj + x;
            // pixels off the stored window or outside the image add nothing
            if (r < WINDOW_SIDE_DEF && c < WINDOW_SIDE_DEF) begin
               px = win_pix[r * WINDOW_SIDE_DEF + c];
               if (px[GRAY_W]) begin
                  a = 32'(px[GRAY_W-1:0]);
                  b = 32'(tpl_pix[y * MAX_TEMPLATE_DEF + x]);
                  acc += (a > b) ? a - b : b - a;
               end
            end
            // the clamp applies after every pixel, not only at the end
            if (acc > cfg_sat)
               acc = 32'(cfg_sat);
         end
      end
      return acc;
   endfunction

   // row-major walk over the offsets, keeping the first strict minimum
   function automatic rsp_type predict_match();
      int unsigned ow;
      int unsigned oh;
      int unsigned tw;
      int unsigned th;
      int unsigned best;
      int unsigned cost;
      int unsigned bi;
      int unsigned bj;
      logic        hit;
      rsp_type     res;
      ow   = eff_offsets(cfg_ow);
      oh   = eff_offsets(cfg_oh);
      tw   = eff_tpl(cfg_tw);
      th   = eff_tpl(cfg_th);
      best = offset_cost(0, 0, th, tw);
      bi   = 0;
      bj   = 0;
      hit  = 1'b0;
      for (int i = 0; i < oh; i++) begin
         for (int j = 0; j < ow; j++) begin
            if (i == 0 && j == 0)
               continue;
            cost = offset_cost(i, j, th, tw);
            if (cost < best) begin
               best = cost;
               bi   = i;
               bj   = j;
               hit  = 1'b1;
            end
         end
      end
      res.found    = hit;
      res.match_x  = POS_W'(bj + edge_start(cfg_cx) + tw);
      res.match_y  = POS_W'(bi + edge_start(cfg_cy));
      res.best_sum = SUM_W'(best);
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_fault(input string msg);
      if (fault_count < 10)
         $display("ERROR at %0t: %s", $time, msg);
      fault_count++;
   endfunction

   // every strobed result is taken at the edge closing its cycle
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_matches.size() == 0) begin
            note_fault($sformatf("result with none expected: found %0d x %0d y %0d sum %0d",
                                 rsp_data.found, rsp_data.match_x, rsp_data.match_y,
                                 rsp_data.best_sum));
         end else begin
            want = pending_matches.pop_front();
            if (rsp_data.found !== want.found || rsp_data.match_x !== want.match_x ||
                rsp_data.match_y !== want.match_y || rsp_data.best_sum !== want.best_sum) begin
               note_fault($sformatf({"match differs: expected found %0d x %0d y %0d sum %0d,",
                                     " got found %0d x %0d y %0d sum %0d"},
                                    want.found, want.match_x, want.match_y, want.best_sum,
                                    rsp_data.found, rsp_data.match_x, rsp_data.match_y,
                                    rsp_data.best_sum));
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // one transaction: random idle cycles first, then hold start until busy lets it in;
   // start is left high so that a following transaction needs no second assignment
   task automatic send_item(input req_type item);
      int idx;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      // accepted at this edge: bring the shadow state up to date
      case (item.operation)
         OP_LOAD_TPL: begin
            // coordinates past the template memory are dropped
            if (item.pix_row < MAX_TEMPLATE_DEF && item.pix_col < MAX_TEMPLATE_DEF) begin
               idx = item.pix_row * MAX_TEMPLATE_DEF + item.pix_col;
               tpl_pix[idx]    = item.gray;
               tpl_loaded[idx] = 1'b1;
               items_sent++;
            end
         end
         OP_LOAD_WIN: begin
            if (item.pix_row < WINDOW_SIDE_DEF && item.pix_col < WINDOW_SIDE_DEF) begin
               idx = item.pix_row * WINDOW_SIDE_DEF + item.pix_col;
               win_pix[idx]    = {item.in_image, item.gray};
               win_loaded[idx] = 1'b1;
               items_sent++;
            end
         end
         OP_SEARCH: begin
            pending_matches.push_back(predict_match());
            searches_sent++;
            items_sent++;
         end
         default: ;
      endcase
   endtask

   task automatic load_pixel(input op_type op, input int row, input int col, input int gray,
                             input bit inimg);
      req_type item;
      item.operation = op;
      item.pix_row   = COORD_W'(row);
      item.pix_col   = COORD_W'(col);
      item.gray      = GRAY_W'(gray);
      item.in_image  = inimg;
      send_item(item);
   endtask

   // a search may only read loaded pixels: fill whatever it would touch with random data
   // (a zero template size still walks one pixel, so at least one is covered)
   task automatic fill_search_area();
      int tw;
      int th;
      int rows;
      int cols;
      tw = eff_tpl(cfg_tw);
      th = eff_tpl(cfg_th);
      if (tw == 0)
         tw = 1;
      if (th == 0)
         th = 1;
      rows = eff_offsets(cfg_oh) + th - 1;
      cols = eff_offsets(cfg_ow) + tw - 1;
      for (int y = 0; y < th; y++) begin
         for (int x = 0; x < tw; x++) begin
            if (!tpl_loaded[y * MAX_TEMPLATE_DEF + x])
               load_pixel(OP_LOAD_TPL, y, x, $urandom_range(255), 1'($urandom_range(1)));
         end
      end
      for (int r = 0; r < rows && r < WINDOW_SIDE_DEF; r++) begin
         for (int c = 0; c < cols && c < WINDOW_SIDE_DEF; c++) begin
            if (!win_loaded[r * WINDOW_SIDE_DEF + c])
               load_pixel(OP_LOAD_WIN, r, c, $urandom_range(255), $urandom_range(9) < 8);
         end
      end
   endtask

   // search transaction; the pixel fields are don't-care and get random bits
   task automatic run_search();
      req_type item;
      fill_search_area();
      item           = REQ_W'($urandom);
      item.operation = OP_SEARCH;
      send_item(item);
   endtask

   // hold off until every expected result is in, then give the pipeline time to empty
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_matches.size() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   // write all seven registers while the block is idle; bits above each register's
   // width carry junk that must be dropped
   task automatic apply_settings(input logic [SUM_W-1:0] lim,
                                 input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                                 input logic [OFFS_CFG_W-1:0] ow,
                                 input logic [OFFS_CFG_W-1:0] oh,
                                 input logic [TPL_CFG_W-1:0] tw, input logic [TPL_CFG_W-1:0] th);
      logic [CSR_DATA_W-1:0] value [7];
      logic [CSR_DATA_W-1:0] junk;
      wait_for_results();
      while (busy)
         @(posedge clock);
      junk     = CSR_DATA_W'($urandom);
      value[0] = lim;
      value[1] = (junk << CENTER_W) | CSR_DATA_W'(cx);
      junk     = CSR_DATA_W'($urandom);
      value[2] = (junk << CENTER_W) | CSR_DATA_W'(cy);
      junk     = CSR_DATA_W'($urandom);
      value[3] = (junk << OFFS_CFG_W) | CSR_DATA_W'(ow);
      junk     = CSR_DATA_W'($urandom);
      value[4] = (junk << OFFS_CFG_W) | CSR_DATA_W'(oh);
      junk     = CSR_DATA_W'($urandom);
      value[5] = (junk << TPL_CFG_W) | CSR_DATA_W'(tw);
      junk     = CSR_DATA_W'($urandom);
      value[6] = (junk << TPL_CFG_W) | CSR_DATA_W'(th);
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= value[i];
         @(posedge clock);
         case (csr_reg_type'(i))
            REG_SAT_LIMIT:    cfg_sat = SUM_W'(value[i]);
            REG_CENTER_X:     cfg_cx  = CENTER_W'(value[i]);
            REG_CENTER_Y:     cfg_cy  = CENTER_W'(value[i]);
            REG_OFFSETS_WIDE: cfg_ow  = OFFS_CFG_W'(value[i]);
            REG_OFFSETS_HIGH: cfg_oh  = OFFS_CFG_W'(value[i]);
            REG_TPL_WIDE:     cfg_tw  = TPL_CFG_W'(value[i]);
            REG_TPL_HIGH:     cfg_th  = TPL_CFG_W'(value[i]);
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // registers straight out of reset apart from a one-pixel template: all 16 by 16
   // offsets with the reset ceiling and edges
   task automatic test_reset_search();
      csr_we    <= 1'b1;
      csr_index <= REG_TPL_WIDE;
      csr_wdata <= CSR_DATA_W'(1);
      @(posedge clock);
      cfg_tw     = 6'd1;
      csr_index <= REG_TPL_HIGH;
      @(posedge clock);
      cfg_th  = 6'd1;
      csr_we <= 1'b0;
      run_search();
      wait_for_results();
   endtask

   // ties keep the earliest offset; out-of-image pixels are skipped
   task automatic test_first_minimum();
      apply_settings(SUM_W'(SAT_RESET), 0, 0, 3, 1, 1, 1);
      load_pixel(OP_LOAD_TPL, 0, 0, 100, 1'b1);
      for (int c = 0; c < 3; c++)
         load_pixel(OP_LOAD_WIN, 0, c, 100, 1'b1);
      // three equal sums: offset (0,0) stays, found low
      run_search();
      load_pixel(OP_LOAD_WIN, 0, 0, 200, 1'b1);
      // outside the image, so a zero sum despite the grey level
      load_pixel(OP_LOAD_WIN, 0, 1, 7, 1'b0);
      // (0,1) and (0,2) both reach zero, the first of them must win
      run_search();
   endtask

   // field extremes, loads past the template memory, and the spare operation code
   task automatic test_field_extremes();
      req_type item;
      apply_settings(SUM_W'(SAT_RESET), 0, 0, 1, 1, 1, 10);
      load_pixel(OP_LOAD_TPL, 9, 0, 255, 1'b1);
      // these must not alias onto row 9 or column 0
      load_pixel(OP_LOAD_TPL, 41, 0, 0, 1'b0);
      load_pixel(OP_LOAD_TPL, 9, 32, 0, 1'b0);
      load_pixel(OP_LOAD_TPL, 63, 63, 0, 1'b1);
      load_pixel(OP_LOAD_WIN, 9, 0, 0, 1'b1);
      load_pixel(OP_LOAD_WIN, 63, 63, 255, 1'b1);
      load_pixel(OP_LOAD_WIN, 0, 63, 0, 1'b0);
      // all ones: spare code, no result and no store write
      item = '1;
      send_item(item);
      run_search();
   endtask

   // running-sum ceiling at zero, tiny and at its maximum
   task automatic test_sat_limit();
      apply_settings(0, 0, 0, 4, 4, 4, 4);
      run_search();
      apply_settings(37, 0, 0, 4, 4, 4, 4);
      run_search();
      apply_settings({SUM_W{1'b1}}, 0, 0, 4, 4, 4, 4);
      run_search();
   endtask

   // edges of the search area around the floor at zero and at the top of the range
   task automatic test_edge_offsets();
      apply_settings(SUM_W'(SAT_RESET), 15, 16, 3, 3, 2, 2);
      run_search();
      apply_settings(SUM_W'(SAT_RESET), 16, 15, 3, 3, 2, 2);
      run_search();
      apply_settings(SUM_W'(SAT_RESET), 4095, 4095, 16, 16, 1, 1);
      run_search();
   endtask

   // saturated and zero counts, and a write to the spare register slot
   task automatic test_count_clamps();
      apply_settings(SUM_W'(SAT_RESET), 0, 0, 31, 2, 63, 1);
      run_search();
      apply_settings(SUM_W'(SAT_RESET), 0, 0, 0, 20, 1, 63);
      run_search();
      // empty template: every sum is zero
      apply_settings(SUM_W'(SAT_RESET), 40, 40, 4, 4, 0, 0);
      run_search();
      apply_settings(SUM_W'(SAT_RESET), 40, 40, 4, 4, 0, 3);
      run_search();
      // nothing may change on the spare slot
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= REG_UNUSED;
      csr_wdata <= {CSR_DATA_W{1'b1}};
      @(posedge clock);
      csr_we <= 1'b0;
      run_search();
   endtask

   // rounds of new settings, a burst of loads with some noise, then one or two searches
   task automatic run_random_phase(input int idle_pct, input int item_goal);
      int first_item;
      int first_search;
      int cap;
      int pick;
      int twc;
      int thc;
      logic [SUM_W-1:0]      lim;
      logic [CENTER_W-1:0]   cx;
      logic [CENTER_W-1:0]   cy;
      logic [OFFS_CFG_W-1:0] ow;
      logic [OFFS_CFG_W-1:0] oh;
      logic [TPL_CFG_W-1:0]  tw;
      logic [TPL_CFG_W-1:0]  th;
      req_type               item;
      sender_idle_pct = idle_pct;
      first_item      = items_sent;
      first_search    = searches_sent;
      while (items_sent - first_item < item_goal || searches_sent - first_search < 24) begin
         if ($urandom_range(1) == 0) begin
            // mostly small searches, now and then a larger one
            cap = ($urandom_range(15) == 0) ? 20000 : 2500;
            do begin
               ow  = OFFS_CFG_W'(($urandom_range(6) != 0) ? $urandom_range(6, 1)
                                                          : $urandom_range(31));
               oh  = OFFS_CFG_W'(($urandom_range(6) != 0) ? $urandom_range(6, 1)
                                                          : $urandom_range(31));
               tw  = TPL_CFG_W'(($urandom_range(7) != 0) ? $urandom_range(8)
                                                        : $urandom_range(63));
               th  = TPL_CFG_W'(($urandom_range(7) != 0) ? $urandom_range(8)
                                                        : $urandom_range(63));
               twc = (eff_tpl(tw) == 0) ? 1 : eff_tpl(tw);
               thc = (eff_tpl(th) == 0) ? 1 : eff_tpl(th);
            end while (eff_offsets(ow) * eff_offsets(oh) * twc * thc > cap);
            case ($urandom_range(3))
               0:       lim = SUM_W'($urandom_range(3000));
               1:       lim = SUM_W'($urandom);
               default: lim = SUM_W'(SAT_RESET);
            endcase
            cx = CENTER_W'($urandom_range(1) ? $urandom_range(40) : $urandom);
            cy = CENTER_W'($urandom_range(1) ? $urandom_range(40) : $urandom);
            apply_settings(lim, cx, cy, ow, oh, tw, th);
         end else if ($urandom_range(7) == 0) begin
            // sender holds back until the block has returned everything
            wait_for_results();
         end
         repeat ($urandom_range(30)) begin
            pick = $urandom_range(19);
            if (pick < 9)
               load_pixel(OP_LOAD_WIN,
                          $urandom_range(1) ? $urandom_range(15) : $urandom_range(63),
                          $urandom_range(1) ? $urandom_range(15) : $urandom_range(63),
                          $urandom_range(255), $urandom_range(9) < 8);
            else if (pick < 17)
               load_pixel(OP_LOAD_TPL,
                          ($urandom_range(3) != 0) ? $urandom_range(9) : $urandom_range(63),
                          ($urandom_range(3) != 0) ? $urandom_range(9) : $urandom_range(63),
                          $urandom_range(255), 1'($urandom_range(1)));
            else begin
               item           = REQ_W'($urandom);
               item.operation = OP_UNUSED;
               send_item(item);
            end
         end
         run_search();
         // a second search queued behind the first has to wait on busy
         if ($urandom_range(5) == 0)
            run_search();
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 16;
      test_reset_search();
      test_first_minimum();
      test_field_extremes();
      test_sat_limit();
      test_edge_offsets();
      test_count_clamps();

      run_random_phase(16, 300);
      run_random_phase(71, 300);
      run_random_phase(0, 300);

      wait_for_results();
      repeat (16)
         @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
